// ===== hw/rtl/pchip_derivative_stream_top_macros.svh =====
// Assertion macros for the PCHIP derivative stream block.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef PCHIP_DERIVATIVE_STREAM_TOP_MACROS_SVH
`define PCHIP_DERIVATIVE_STREAM_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PCD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PCD_ASSERT(lbl, prop, msg)
`define PCD_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/pcd_pkg.sv =====
// Shared types, codes and helper functions of the PCHIP derivative stream block.
// No dependencies; used by the divider, datapath, controller and top level.
package pcd_pkg;

	localparam int IDX_W = 16;
	localparam int DIV_N = 64;   // quotient bits produced by the divider
	localparam int DVS_W = 35;   // divisor width

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ONE  = 2'd1;
	localparam logic [1:0] ST_TIME = 2'd2;

	// Divider operations
	localparam logic [2:0] OP_SEC = 3'd0;
	localparam logic [2:0] OP_END = 3'd1;
	localparam logic [2:0] OP_W   = 3'd2;
	localparam logic [2:0] OP_R1  = 3'd3;
	localparam logic [2:0] OP_R2  = 3'd4;
	localparam logic [2:0] OP_FIN = 3'd5;

	// Source of an emitted derivative
	localparam logic [1:0] RES_ZERO  = 2'd0;
	localparam logic [1:0] RES_SLOPE = 2'd1;
	localparam logic [1:0] RES_CALC  = 2'd2;

	typedef struct packed {
		logic             load;
		logic             upd_prev;
		logic             div_start;
		logic [2:0]       div_op;
		logic             end_right;
		logic             end_mul;
		logic             end_fin;
		logic             int_mul1;
		logic             int_mul2;
		logic             int_den;
		logic             push;
		logic [1:0]       res_sel;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic [1:0]       status;
	} pcd_cmd_t;

	typedef struct packed {
		logic time_bad;
		logic div_done;
		logic div_busy;
		logic out_free;
	} pcd_stat_t;

	// Apply a sign to a magnitude and saturate to 32 bits.
	function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
		logic [31:0] r;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000)
				r = 32'h8000_0000;
			else
				r = ~m[31:0] + 32'd1;
		end else begin
			if (m > 64'h0000_0000_7FFF_FFFF)
				r = 32'h7FFF_FFFF;
			else
				r = m[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/pchip_derivative_stream_top.sv =====
// Top level of the PCHIP derivative stream block: controller plus datapath.
// Depends on pcd_pkg, pcd_ctrl, pcd_dp and the assertion macro header.
//
//   Channel  Direction  Contents (lowest bits first)
//   s_*      in         tdata: sample_time[31:0], sample_value[63:32]; tlast: last_sample
//   m_*      out        tdata: derivative[31:0], point_index[47:32]; tlast: last_result;
//                       tuser: status
//
// One sample is taken at a time; s_tready is high only while the controller is idle.
// Every quotient comes from a single restoring divider that yields one bit per cycle,
// so the divider sets the cost of a sample: no division for a first or dropped sample,
// the secant for the second, the secant plus four divisions for an interior sample,
// and one more division for each end point.
// A result waits in the output register; a stalled m_tready holds the controller only
// when the next result is ready to go. arst_n clears all control state and the history.
`include "pchip_derivative_stream_top_macros.svh"
module pchip_derivative_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_time[31:0], sample_value[63:32]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // derivative[31:0], point_index[47:32]
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // status
);
	import pcd_pkg::*;

	pcd_cmd_t         cmd;
	pcd_stat_t        st;
	logic [31:0]      derivative;
	logic [IDX_W-1:0] point_index;

	// The controller owns the sample count and the drop flag; the datapath owns
	// the history, the arithmetic and the output register.
	pcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	pcd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_time  (s_tdata[31:0]),
		.sample_value (s_tdata[63:32]),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.derivative   (derivative),
		.point_index  (point_index),
		.last_result  (m_tlast),
		.status       (m_tuser)
	);

	assign m_tdata = {point_index, derivative};

	// A new sample must never arrive while a division is still running.
	`PCD_ASSERT(a_idle_div, s_tready |-> !st.div_busy, "sample accepted during division")
	// A result is only loaded when the output register can take it.
	`PCD_ASSERT(a_push_free, cmd.push |-> st.out_free, "result overwrote pending transfer")
	// Error results always carry a zero derivative.
	`PCD_NEVER(a_err_zero, m_tvalid && (m_tuser != ST_OK) && (m_tdata[31:0] != 32'd0),
		"error result with nonzero derivative")

endmodule

// ===== hw/rtl/pcd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned 64 by 35 bits.
// Depends on pcd_pkg for its widths.
module pcd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [63:0]               dividend,
	input  logic [pcd_pkg::DVS_W-1:0] divisor,
	output logic                      busy,
	output logic                      done,
	output logic [63:0]               quotient
);
	import pcd_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [63:0]      dq_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, dq_q[63]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== hw/rtl/pcd_dp.sv =====
// Datapath: sample history, secant and derivative arithmetic, output register.
// Depends on pcd_pkg and instantiates pcd_div.
module pcd_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [31:0]               sample_time,
	input  logic [31:0]               sample_value,
	input  pcd_pkg::pcd_cmd_t         cmd,
	output pcd_pkg::pcd_stat_t        st,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               derivative,
	output logic [pcd_pkg::IDX_W-1:0] point_index,
	output logic                      last_result,
	output logic [1:0]                status
);
	import pcd_pkg::*;

	localparam logic [28:0] W_ONE = 29'd1 << 28;

	logic [31:0] t_q, v_q, prev_time_q, prev_value_q;
	logic [31:0] h_old_q, h_new_q, s_old_q, s_new_q;
	logic [30:0] r_q, r1_q, r2_q, den_q;
	logic [28:0] w1_q;
	logic [63:0] prod_q, prod2_q;
	logic [31:0] res_q;
	logic [2:0]  op_q;

	logic              out_valid_q;
	logic [31:0]       deriv_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;
	logic [1:0]        status_q;

	logic [63:0]      div_a;
	logic [DVS_W-1:0] div_b;
	logic             div_busy, div_done;
	logic [63:0]      quo;

	// secant
	logic [32:0] h_full, dv, dv_mag;
	// end point
	logic [31:0] sn, sf, hn, hf;
	logic [32:0] hsum_e, x, x_mag;
	logic [33:0] sc;
	logic [34:0] sc_s, d, lim, d_mag, lim_mag, d2;
	logic        sn_pos, sn_neg, sf_pos, sf_neg, d_pos, ok_sign, flip;
	logic [31:0] end_res;
	logic [63:0] mul_e;
	// interior
	logic [33:0] num_w;
	logic [32:0] hs;
	logic [34:0] h3;
	logic [31:0] a_mag, b_mag, mx, mn;
	logic        int_same;
	logic [28:0] w2;
	logic [63:0] mul_1, mul_2, den_sum;
	logic [30:0] den;

	assign h_full   = {t_q[31], t_q} - {prev_time_q[31], prev_time_q};
	assign dv       = {v_q[31], v_q} - {prev_value_q[31], prev_value_q};
	assign dv_mag   = dv[32] ? (~dv + 33'd1) : dv;

	assign sn = cmd.end_right ? s_new_q : s_old_q;
	assign sf = cmd.end_right ? s_old_q : s_new_q;
	assign hn = cmd.end_right ? h_new_q : h_old_q;
	assign hf = cmd.end_right ? h_old_q : h_new_q;
	assign hsum_e = {1'b0, hn} + {1'b0, hf};
	assign x      = {sn[31], sn} - {sf[31], sf};
	assign x_mag  = x[32] ? (~x + 33'd1) : x;
	assign mul_e  = x_mag * r_q;

	assign num_w = {1'b0, h_old_q, 1'b0} + {2'd0, h_new_q};
	assign hs    = {1'b0, h_old_q} + {1'b0, h_new_q};
	assign h3    = {2'd0, hs} + {1'b0, hs, 1'b0};
	assign a_mag = s_old_q[31] ? (~s_old_q + 32'd1) : s_old_q;
	assign b_mag = s_new_q[31] ? (~s_new_q + 32'd1) : s_new_q;
	assign mx    = (a_mag > b_mag) ? a_mag : b_mag;
	assign mn    = (a_mag > b_mag) ? b_mag : a_mag;
	assign int_same = (s_old_q != 32'd0) && (s_new_q != 32'd0) && (s_old_q[31] == s_new_q[31]);
	assign w2      = W_ONE - w1_q;
	assign mul_1   = w1_q * r1_q;
	assign mul_2   = w2 * r2_q;
	assign den_sum = prod_q + prod2_q;
	assign den     = den_sum[58:28];

	// End point: shape-limited three-point formula from the stored product.
	always_comb begin
		sc      = prod_q[63:30];
		sc_s    = x[32] ? (~{1'b0, sc} + 35'd1) : {1'b0, sc};
		d       = {{3{sn[31]}}, sn} + sc_s;
		lim     = {{3{sn[31]}}, sn} + {{2{sn[31]}}, sn, 1'b0};
		sn_neg  = sn[31];
		sn_pos  = !sn[31] && (sn != 32'd0);
		sf_neg  = sf[31];
		sf_pos  = !sf[31] && (sf != 32'd0);
		d_pos   = !d[34] && (d != 35'd0);
		ok_sign = (d_pos && sn_pos) || (d[34] && sn_neg);
		flip    = (sn_pos && sf_neg) || (sn_neg && sf_pos);
		d_mag   = d[34] ? (~d + 35'd1) : d;
		lim_mag = lim[34] ? (~lim + 35'd1) : lim;
		d2      = (flip && (lim_mag < d_mag)) ? lim : d;
		if (!ok_sign)
			end_res = 32'd0;
		else if (!d2[34] && (d2[33:31] != 3'b000))
			end_res = 32'h7FFF_FFFF;
		else if (d2[34] && (d2[33:31] != 3'b111))
			end_res = 32'h8000_0000;
		else
			end_res = d2[31:0];
	end

	always_comb begin
		case (cmd.div_op)
			OP_SEC: begin
				div_a = {15'd0, dv_mag, 16'd0};
				div_b = {3'd0, h_full[31:0]};
			end
			OP_END: begin
				div_a = {2'd0, hn, 30'd0};
				div_b = {2'd0, hsum_e};
			end
			OP_W: begin
				div_a = {2'd0, num_w, 28'd0};
				div_b = h3;
			end
			OP_R1: begin
				div_a = {2'd0, a_mag, 30'd0};
				div_b = {3'd0, mx};
			end
			OP_R2: begin
				div_a = {2'd0, b_mag, 30'd0};
				div_b = {3'd0, mx};
			end
			default: begin
				div_a = {2'd0, mn, 30'd0};
				div_b = {4'd0, den_q};
			end
		endcase
	end

	pcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q  <= '0;
			prev_value_q <= '0;
			h_old_q      <= '0;
			h_new_q      <= '0;
			s_old_q      <= '0;
			s_new_q      <= '0;
		end else begin
			if (cmd.upd_prev) begin
				prev_time_q  <= t_q;
				prev_value_q <= v_q;
			end
			if (div_done && (op_q == OP_SEC)) begin
				prev_time_q  <= t_q;
				prev_value_q <= v_q;
				h_old_q      <= h_new_q;
				h_new_q      <= h_full[31:0];
				s_old_q      <= s_new_q;
				s_new_q      <= sat_mag(dv[32], quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= sample_time;
			v_q <= sample_value;
		end
		if (cmd.div_start)
			op_q <= cmd.div_op;
		if (div_done) begin
			case (op_q)
				OP_END: r_q  <= quo[30:0];
				OP_W:   w1_q <= quo[28:0];
				OP_R1:  r1_q <= quo[30:0];
				OP_R2:  r2_q <= quo[30:0];
				OP_FIN: res_q <= int_same ? sat_mag(s_old_q[31], quo) : 32'd0;
				default: ;
			endcase
		end
		if (cmd.end_mul)
			prod_q <= mul_e;
		if (cmd.int_mul1)
			prod_q <= mul_1;
		if (cmd.int_mul2)
			prod2_q <= mul_2;
		if (cmd.int_den)
			den_q <= (den == 31'd0) ? 31'd1 : den;
		if (cmd.end_fin)
			res_q <= end_res;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			case (cmd.res_sel)
				RES_SLOPE: deriv_q <= s_new_q;
				RES_CALC:  deriv_q <= res_q;
				default:   deriv_q <= 32'd0;
			endcase
			idx_q    <= cmd.idx;
			last_q   <= cmd.last;
			status_q <= cmd.status;
		end
	end

	assign st.time_bad = $signed(t_q) <= $signed(prev_time_q);
	assign st.div_done = div_done;
	assign st.div_busy = div_busy;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign derivative  = deriv_q;
	assign point_index = idx_q;
	assign last_result = last_q;
	assign status      = status_q;

endmodule

// ===== hw/rtl/pcd_ctrl.sv =====
// Controller: sequences sample handling, divisions and result transfers.
// Depends on pcd_pkg; drives the datapath through pcd_cmd_t.
module pcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  pcd_pkg::pcd_stat_t st,
	output pcd_pkg::pcd_cmd_t  cmd
);
	import pcd_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DECIDE   = 5'd1;
	localparam logic [4:0] S_ONE_EMIT = 5'd2;
	localparam logic [4:0] S_ERR_EMIT = 5'd3;
	localparam logic [4:0] S_SEC_WAIT = 5'd4;
	localparam logic [4:0] S_LIN0     = 5'd5;
	localparam logic [4:0] S_LIN1     = 5'd6;
	localparam logic [4:0] S_END_GO   = 5'd7;
	localparam logic [4:0] S_END_WAIT = 5'd8;
	localparam logic [4:0] S_END_MUL  = 5'd9;
	localparam logic [4:0] S_END_FIN  = 5'd10;
	localparam logic [4:0] S_END_EMIT = 5'd11;
	localparam logic [4:0] S_INT_GO   = 5'd12;
	localparam logic [4:0] S_INT_W    = 5'd13;
	localparam logic [4:0] S_INT_R1   = 5'd14;
	localparam logic [4:0] S_INT_R2   = 5'd15;
	localparam logic [4:0] S_INT_MUL1 = 5'd16;
	localparam logic [4:0] S_INT_MUL2 = 5'd17;
	localparam logic [4:0] S_INT_DEN  = 5'd18;
	localparam logic [4:0] S_INT_FGO  = 5'd19;
	localparam logic [4:0] S_INT_FIN  = 5'd20;
	localparam logic [4:0] S_INT_EMIT = 5'd21;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	logic [4:0]       state_q, state_d;
	logic [IDX_W-1:0] count_q, count_d;
	logic             dropping_q, dropping_d;
	logic             last_q, last_d;
	logic             right_q, right_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dropping_q <= 1'b0;
			last_q     <= 1'b0;
			right_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			dropping_q <= dropping_d;
			last_q     <= last_d;
			right_q    <= right_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		dropping_d    = dropping_q;
		last_d        = last_q;
		right_d       = right_q;
		cmd           = '0;
		cmd.end_right = right_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					last_d   = in_last;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (dropping_q) begin
					if (last_q) begin
						dropping_d = 1'b0;
						count_d    = '0;
					end
					state_d = S_IDLE;
				end else if (count_q == '0) begin
					cmd.upd_prev = 1'b1;
					if (last_q)
						state_d = S_ONE_EMIT;
					else begin
						count_d = IDX_W'(1);
						state_d = S_IDLE;
					end
				end else if (st.time_bad) begin
					state_d = S_ERR_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_SEC;
					state_d       = S_SEC_WAIT;
				end
			end
			S_ONE_EMIT: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_ZERO;
					cmd.last    = 1'b1;
					cmd.status  = ST_ONE;
					state_d     = S_IDLE;
				end
			end
			S_ERR_EMIT: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_ZERO;
					cmd.idx     = count_q;
					cmd.last    = 1'b1;
					cmd.status  = ST_TIME;
					count_d     = '0;
					dropping_d  = !last_q;
					state_d     = S_IDLE;
				end
			end
			S_SEC_WAIT: begin
				if (st.div_done) begin
					if (count_q == IDX_W'(1)) begin
						if (last_q)
							state_d = S_LIN0;
						else begin
							count_d = IDX_W'(2);
							state_d = S_IDLE;
						end
					end else if (count_q == IDX_W'(2)) begin
						right_d = 1'b0;
						state_d = S_END_GO;
					end else begin
						state_d = S_INT_GO;
					end
				end
			end
			S_LIN0: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_SLOPE;
					cmd.status  = ST_OK;
					state_d     = S_LIN1;
				end
			end
			S_LIN1: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_SLOPE;
					cmd.idx     = IDX_W'(1);
					cmd.last    = 1'b1;
					cmd.status  = ST_OK;
					count_d     = '0;
					state_d     = S_IDLE;
				end
			end
			S_END_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_END;
				state_d       = S_END_WAIT;
			end
			S_END_WAIT: begin
				if (st.div_done)
					state_d = S_END_MUL;
			end
			S_END_MUL: begin
				cmd.end_mul = 1'b1;
				state_d     = S_END_FIN;
			end
			S_END_FIN: begin
				cmd.end_fin = 1'b1;
				state_d     = S_END_EMIT;
			end
			S_END_EMIT: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_CALC;
					cmd.idx     = right_q ? count_q : '0;
					cmd.last    = right_q;
					cmd.status  = ST_OK;
					if (right_q) begin
						count_d = '0;
						state_d = S_IDLE;
					end else begin
						state_d = S_INT_GO;
					end
				end
			end
			S_INT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_W;
				state_d       = S_INT_W;
			end
			S_INT_W: begin
				if (st.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_R1;
					state_d       = S_INT_R1;
				end
			end
			S_INT_R1: begin
				if (st.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_R2;
					state_d       = S_INT_R2;
				end
			end
			S_INT_R2: begin
				if (st.div_done)
					state_d = S_INT_MUL1;
			end
			S_INT_MUL1: begin
				cmd.int_mul1 = 1'b1;
				state_d      = S_INT_MUL2;
			end
			S_INT_MUL2: begin
				cmd.int_mul2 = 1'b1;
				state_d      = S_INT_DEN;
			end
			S_INT_DEN: begin
				cmd.int_den = 1'b1;
				state_d     = S_INT_FGO;
			end
			S_INT_FGO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_FIN;
				state_d       = S_INT_FIN;
			end
			S_INT_FIN: begin
				if (st.div_done)
					state_d = S_INT_EMIT;
			end
			S_INT_EMIT: begin
				if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.res_sel = RES_CALC;
					cmd.idx     = count_q - IDX_W'(1);
					cmd.status  = ST_OK;
					if (last_q) begin
						right_d = 1'b1;
						state_d = S_END_GO;
					end else begin
						if (count_q != IDX_MAX)
							count_d = count_q + IDX_W'(1);
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for pchip_derivative_stream_top: samples go in as sequences,
// derivatives are predicted here and compared with every result transfer.
// Depends on pcd_pkg and the RTL of the block; reads no files.
module tb_top;
	import pcd_pkg::*;

	localparam int      HOLD_CYCLES = 3000;
	localparam longint  CYCLE_LIMIT = 2000000;
	localparam int      DRAIN_CYCLES = 600;
	localparam int      TOTAL_ITEMS = 210;

	typedef struct {
		logic [31:0] stamp;
		logic [31:0] value;
		logic        last;
	} sample_t;

	typedef struct {
		logic [31:0] deriv;
		logic [15:0] idx;
		logic        last;
		logic [1:0]  status;
	} deriv_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	sample_t    pending_samples[$];
	deriv_res_t expected_derivs[$];
	sample_t    offered;
	int         mismatches = 0;
	int         accepted_samples = 0;
	longint     cycle_count = 0;
	logic       bursty = 1'b0;

	// Predictor state: the history of the current sequence.
	longint      prev_stamp, prev_value, slope_older, slope_newer;
	logic [63:0] width_older, width_newer;
	int unsigned sample_index;
	logic        skipping;

	pchip_derivative_stream_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic int sign_of(longint x);
		return (x > 0) - (x < 0);
	endfunction

	function automatic logic [63:0] abs_of(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint signed_mag(logic [63:0] m, int s);
		return s < 0 ? -longint'(m) : longint'(m);
	endfunction

	// Shape-limited three-point slope at an end point of the sequence.
	function automatic longint end_slope(longint s_near, longint s_far,
			logic [63:0] h_near, logic [63:0] h_far);
		logic [63:0] r;
		longint      diff, d, lim;
		r = (h_near << 30) / (h_near + h_far);
		diff = s_near - s_far;
		d = s_near + signed_mag((abs_of(diff) * r) >> 30, sign_of(diff));
		if (sign_of(d) * sign_of(s_near) <= 0)
			return 0;
		if (sign_of(s_near) * sign_of(s_far) < 0) begin
			lim = 3 * s_near;
			if (abs_of(lim) < abs_of(d))
				d = lim;
		end
		return clamp32(d);
	endfunction

	// Weighted harmonic mean of the two secants around an interior point.
	function automatic longint interior_slope(longint s1, longint s2,
			logic [63:0] h1, logic [63:0] h2);
		logic [63:0] w1, w2, a, b, hi, lo, r1, r2, den;
		if (sign_of(s1) * sign_of(s2) <= 0)
			return 0;
		w1 = ((2 * h1 + h2) << 28) / (3 * (h1 + h2));
		w2 = (64'd1 << 28) - w1;
		a = abs_of(s1);
		b = abs_of(s2);
		hi = a > b ? a : b;
		lo = a > b ? b : a;
		r1 = (a << 30) / hi;
		r2 = (b << 30) / hi;
		den = (w1 * r1 + w2 * r2) >> 28;
		if (den == 0)
			den = 1;
		return clamp32(signed_mag((lo << 30) / den, sign_of(s1)));
	endfunction

	function automatic logic [15:0] point_of(int unsigned i);
		return i > 65535 ? 16'hFFFF : 16'(i);
	endfunction

	task automatic push_deriv(longint d, logic [15:0] idx, logic last, logic [1:0] st);
		deriv_res_t r;
		r.deriv = d[31:0];
		r.idx = idx;
		r.last = last;
		r.status = st;
		expected_derivs = {expected_derivs, r};
	endtask

	// Advances the predicted history by one accepted sample and queues its results.
	task automatic predict_derivs(sample_t smp);
		longint      t, v, s;
		logic [63:0] h;
		int unsigned n;
		t = longint'(signed'(smp.stamp));
		v = longint'(signed'(smp.value));
		n = sample_index;
		if (skipping) begin
			if (smp.last) begin
				skipping = 1'b0;
				sample_index = 0;
			end
			return;
		end
		if (n == 0) begin
			prev_stamp = t;
			prev_value = v;
			if (smp.last)
				push_deriv(0, 16'd0, 1'b1, ST_ONE);
			else
				sample_index = 1;
			return;
		end
		if (t <= prev_stamp) begin
			push_deriv(0, point_of(n), 1'b1, ST_TIME);
			sample_index = 0;
			skipping = !smp.last;
			return;
		end
		h = 64'(t - prev_stamp);
		s = clamp32(signed_mag((abs_of(v - prev_value) << 16) / h, sign_of(v - prev_value)));
		prev_stamp = t;
		prev_value = v;
		width_older = width_newer;
		width_newer = h;
		slope_older = slope_newer;
		slope_newer = s;
		if (n == 1) begin
			if (smp.last) begin
				push_deriv(s, 16'd0, 1'b0, ST_OK);
				push_deriv(s, 16'd1, 1'b1, ST_OK);
				sample_index = 0;
			end else
				sample_index = 2;
			return;
		end
		if (n == 2)
			push_deriv(end_slope(slope_older, slope_newer, width_older, width_newer),
				16'd0, 1'b0, ST_OK);
		push_deriv(interior_slope(slope_older, slope_newer, width_older, width_newer),
			point_of(n - 1), 1'b0, ST_OK);
		if (smp.last) begin
			push_deriv(end_slope(slope_newer, slope_older, width_newer, width_older),
				point_of(n), 1'b1, ST_OK);
			sample_index = 0;
		end else if (n < 65535)
			sample_index = n + 1;
	endtask

	// Mostly short gaps, now and then a long one, none at all while bursty is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (bursty || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic add_sample(logic [31:0] t, logic [31:0] v, logic last);
		sample_t smp;
		smp.stamp = t;
		smp.value = v;
		smp.last = last;
		pending_samples = {pending_samples, smp};
	endtask

	// Queues one sequence of n samples with random steps and value shapes; a large step can wrap the time.
	task automatic add_sequence(int n);
		logic [31:0] t, v, step;
		int          shape;
		t = $urandom();
		if (t[31] == 1'b0 && $urandom_range(0, 1))
			t = t >> 8;
		v = $urandom();
		shape = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			add_sample(t, v, i == n - 1);
			case ($urandom_range(0, 9))
				0: step = 32'd1;
				1, 2: step = $urandom_range(1, 32'h00FF_FFFF);
				3: step = $urandom();
				default: step = $urandom_range(32'h0000_1000, 32'h0004_0000);
			endcase
			t = t + step;
			case (shape)
				0: v = $urandom();
				1: v = v + $urandom_range(0, 32'h0010_0000);
				2: v = v - $urandom_range(0, 32'h0010_0000);
				default: v = $urandom_range(0, 3) == 0 ? v : v + 32'($signed($urandom_range(0,
					32'h0020_0000)) - 32'sh0010_0000);
			endcase
		end
	endtask

	// Driver: offers queued samples with random gaps and predicts each accepted one.
	int send_gap = 0;
	always @(posedge clk) begin
		if (cycle_count % 500 == 0)
			bursty <= ($urandom_range(0, 4) == 0);
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_derivs(offered);
				accepted_samples <= accepted_samples + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					offered = pending_samples.pop_front();
					s_tdata <= {offered.value, offered.stamp};
					s_tlast <= offered.last;
					s_tvalid <= 1'b1;
					send_gap <= pick_gap();
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, and one long hold-off early in the random part so that
	// the block fills up and stops taking samples while the driver keeps offering.
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted_samples >= 40) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		deriv_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_derivs.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result: deriv=%h idx=%0d last=%b status=%0d",
						m_tdata[31:0], m_tdata[47:32], m_tlast, m_tuser);
			end else begin
				want = expected_derivs.pop_front();
				if (m_tdata[31:0] !== want.deriv || m_tdata[47:32] !== want.idx ||
						m_tlast !== want.last || m_tuser !== want.status) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: got deriv=%h idx=%0d last=%b status=%0d, %s%h %0d %b %0d",
							m_tdata[31:0], m_tdata[47:32], m_tlast, m_tuser, "wanted ",
							want.deriv, want.idx, want.last, want.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pchip_derivative_stream_top verification failed");
			$finish;
		end
	end

	initial begin
		skipping = 1'b0;
		sample_index = 0;
		prev_stamp = 0;
		prev_value = 0;
		slope_older = 0;
		slope_newer = 0;
		width_older = 0;
		width_newer = 0;

		// Directed part. A lone sample at the field extremes.
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		// Two samples: the linear slope at both points.
		add_sample(32'h0001_0000, 32'h0000_0000, 1'b0);
		add_sample(32'h0003_0000, 32'h0005_0000, 1'b1);
		// Smallest step against the widest rise: both secant slopes saturate.
		add_sample(32'h7FFF_FFFD, 32'h8000_0000, 1'b0);
		add_sample(32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		// A peak: zero at the interior extremum.
		add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_sample(32'h0000_1000, 32'h0010_0000, 1'b0);
		add_sample(32'h0010_0000, 32'h0011_0000, 1'b0);
		add_sample(32'h0011_0000, 32'h0000_0000, 1'b1);
		// Flat stretch, then a zero secant next to a rising one.
		add_sample(32'hFFFF_0000, 32'h1234_5678, 1'b0);
		add_sample(32'h0000_0000, 32'h1234_5678, 1'b0);
		add_sample(32'h0002_0000, 32'h1334_5678, 1'b1);
		// Repeated time at the second sample while more follow: the rest is dropped.
		add_sample(32'h0005_0000, 32'h0000_0001, 1'b0);
		add_sample(32'h0005_0000, 32'h0000_0002, 1'b0);
		add_sample(32'h0006_0000, 32'h0000_0003, 1'b0);
		add_sample(32'h0007_0000, 32'h0000_0004, 1'b1);
		// Time going back on the final sample, after derivatives were emitted.
		add_sample(32'h0000_0000, 32'hFFFF_0000, 1'b0);
		add_sample(32'h0001_0000, 32'hFFFE_0000, 1'b0);
		add_sample(32'h0002_0000, 32'hFFF0_0000, 1'b0);
		add_sample(32'h0001_8000, 32'h0000_0000, 1'b1);

		// Random part: mostly well-formed sequences, some broken ones and lone samples.
		while (pending_samples.size() < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0: add_sample($urandom(), $urandom(), 1'($urandom_range(0, 1)));
				1: begin
					add_sequence($urandom_range(2, 4));
					pending_samples[$].last = 1'b0;
					add_sample(pending_samples[$].stamp - $urandom_range(0, 3), $urandom(),
						1'($urandom_range(0, 1)));
					add_sequence($urandom_range(1, 3));
				end
				2: add_sequence($urandom_range(12, 30));
				default: add_sequence($urandom_range(2, 8));
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_samples.size() == 0 && !s_tvalid);
		wait (expected_derivs.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_derivs.size() == 0)
			$display("pchip_derivative_stream_top verification clean");
		else
			$display("pchip_derivative_stream_top verification failed");
		$finish;
	end
endmodule
